@@ rtl/core/ects_pkg.sv @@
// ects_pkg: shared types, constants and reset values for the EMA crossover trade simulator
// no dependencies; imported by every module of the block
package ects_pkg;

  // fixed-point layout defaults
  localparam int WEIGHT_FRAC_BITS_DEF  = 16;
  localparam int AVG_FRAC_BITS_DEF     = 16;
  localparam int HOLDING_FRAC_BITS_DEF = 32;

  // field widths
  localparam int PRICE_W   = 32;
  localparam int WEIGHT_W  = 17;
  localparam int AVG_W     = 48;
  localparam int BAL_W     = 48;
  localparam int CHANGE_W  = 49;
  localparam int HOLD_W    = 64;
  localparam int PRIME_W   = 16;
  localparam int COUNT_W   = 32;
  localparam int ACC_W     = 96;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 48;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 232;

  // register reset values
  localparam logic [WEIGHT_W-1:0] FAST_WEIGHT_RST      = 17'd461;
  localparam logic [WEIGHT_W-1:0] SLOW_WEIGHT_RST      = 17'd291;
  localparam logic [BAL_W-1:0]    STARTING_BALANCE_RST = 48'd1000000;
  localparam logic [PRIME_W-1:0]  PRIME_COUNT_RST      = 16'd1000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FAST_WEIGHT      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_WEIGHT      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STARTING_BALANCE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_COUNT      = 8'd3;

  // shift applied to a product before accumulation
  typedef enum logic [1:0] {
    SH_NONE,
    SH_WORD,
    SH_AVG
  } shift_sel_t;

  // one multiply-accumulate request
  typedef struct packed {
    logic        vld;
    logic        clr;
    logic [31:0] a;
    logic [31:0] b;
    shift_sel_t  sh;
  } mac_req_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FAST,
    ST_SLOW,
    ST_TRADE,
    ST_DIV,
    ST_SELL,
    ST_MARK,
    ST_DONE
  } seq_state_t;

endpackage

@@ rtl/core/ema_crossover_trade_simulator.sv @@
// ema_crossover_trade_simulator: top level, sequencer and state of the trade simulator
// depends on ects_pkg, ects_mac, ects_div
//
// Usage: one price bar per input transfer on in_* (tdata = weighted, high, low price,
// 32 bits each, cents). Each bar yields exactly one result transfer on out_*.
// Configuration writes on cfg_* (index 0 fast weight, 1 slow weight, 2 starting
// balance, 3 prime count) are taken every cycle and must come while no bar is in work.
// Writing the starting balance reloads cash and the last marked balance and clears
// holdings.
// Sequence: both averages are computed in turn on one shared 32x32 multiply-accumulate
// unit, then come the trade decision, the mark-to-market and the accept and output
// handoff. A bar that executes a buy also runs the bit-serial divider, one quotient
// bit per cycle, before the mark-to-market; a bar that executes a sell adds a sell
// phase on the multiply-accumulate unit before the mark-to-market.
// in_tready is high only in the idle state. The result sits in an output register,
// so the next bar is accepted while a result waits; if the receiver stalls the
// following result holds in the sequencer until the register frees.
// Reset (synchronous, rst_n low) clears averages, counters, pending and valid flags,
// loads default registers, and sets cash and last marked balance to 1000000 cents.
module ema_crossover_trade_simulator #(
  parameter int WEIGHT_FRAC_BITS  = ects_pkg::WEIGHT_FRAC_BITS_DEF,
  parameter int AVG_FRAC_BITS     = ects_pkg::AVG_FRAC_BITS_DEF,
  parameter int HOLDING_FRAC_BITS = ects_pkg::HOLDING_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // vwap [31:0], bar_high [63:32], bar_low [95:64]
  input  logic [ects_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // primed [0], buy_flag [1], sell_flag [2], fast_average [50:3],
  // slow_average [98:51], marked_balance [146:99], balance_change [195:147],
  // buys_made [227:196], zero [231:228]
  output logic [ects_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ects_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ects_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import ects_pkg::*;

  localparam int NUM_W = BAL_W + HOLDING_FRAC_BITS;

  // configuration
  logic [WEIGHT_W-1:0] fast_w_r, slow_w_r;
  logic [PRIME_W-1:0]  prime_cnt_r;

  // bar state
  seq_state_t state_r, state_nxt;
  logic [2:0]          cnt_r;
  logic [PRICE_W-1:0]  wp_r, hp_r, lp_r;
  logic [AVG_W-1:0]    fast_avg_r, slow_avg_r, prev_fast_r, prev_slow_r;
  logic [PRIME_W-1:0]  primer_r;
  logic                primed_r, buy_pend_r, sell_pend_r;
  logic                new_buy_r, new_sell_r, do_sell_r;
  logic [BAL_W-1:0]    cash_r, last_marked_r;
  logic [HOLD_W-1:0]   hold_r;
  logic [COUNT_W-1:0]  buy_cnt_r;
  logic [CHANGE_W-1:0] change_r;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // shared units
  mac_req_t         mac_req;
  logic [ACC_W-1:0] acc;
  logic             div_start, div_done;
  logic [63:0]      div_q;

  logic             in_xfer, out_xfer, slot_free;
  logic             phase_end;
  logic [31:0]      one_w, fast_wc, slow_wc, omw_fast, omw_slow;
  logic [ACC_W-1:0] avg_shift, hold_shift;
  logic [BAL_W-1:0] hold_val;
  logic [BAL_W:0]   cash_sum;
  logic [BAL_W-1:0] cash_sat;
  logic [PRIME_W-1:0] primer_inc;
  logic             primed_now, buy_now, sell_now, do_buy, do_sell;
  logic [HOLD_W:0]  hold_sum;

  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_valid_r && out_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // weights clamped to one and their complements
  assign one_w    = 32'd1 << WEIGHT_FRAC_BITS;
  assign fast_wc  = (32'(fast_w_r) > one_w) ? one_w : 32'(fast_w_r);
  assign slow_wc  = (32'(slow_w_r) > one_w) ? one_w : 32'(slow_w_r);
  assign omw_fast = one_w - fast_wc;
  assign omw_slow = one_w - slow_wc;

  // accumulator views
  assign avg_shift  = acc >> WEIGHT_FRAC_BITS;
  assign hold_shift = acc >> HOLDING_FRAC_BITS;
  assign hold_val   = (|hold_shift[ACC_W-1:BAL_W]) ? '1 : hold_shift[BAL_W-1:0];
  assign cash_sum   = {1'b0, cash_r} + {1'b0, hold_val};
  assign cash_sat   = cash_sum[BAL_W] ? '1 : cash_sum[BAL_W-1:0];

  // priming and crossover decision
  assign primer_inc = (primer_r != '1) ? primer_r + 1'b1 : primer_r;
  assign primed_now = primed_r || (primer_inc > prime_cnt_r);
  assign do_buy     = primed_now && buy_pend_r && !sell_pend_r && (hp_r != '0);
  assign do_sell    = primed_now && sell_pend_r && !buy_pend_r;
  assign buy_now    = primed_now && !buy_pend_r && (fast_avg_r > slow_avg_r)
                      && (prev_fast_r <= prev_slow_r);
  assign sell_now   = primed_now && !sell_pend_r && (fast_avg_r < slow_avg_r)
                      && (prev_fast_r >= prev_slow_r);
  assign hold_sum   = {1'b0, hold_r} + {1'b0, div_q};

  assign phase_end = ((state_r == ST_FAST || state_r == ST_SLOW) && cnt_r == 3'd4)
                  || ((state_r == ST_SELL || state_r == ST_MARK) && cnt_r == 3'd3);

  ects_mac #(
    .AVG_FRAC_BITS(AVG_FRAC_BITS)
  ) u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mac_req),
    .acc  (acc)
  );

  ects_div #(
    .NUM_W(NUM_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend({cash_r, HOLDING_FRAC_BITS'(0)}),
    .divisor (hp_r),
    .done    (div_done),
    .quotient(div_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = ST_FAST;
      ST_FAST:  if (phase_end) state_nxt = ST_SLOW;
      ST_SLOW:  if (phase_end) state_nxt = ST_TRADE;
      ST_TRADE: begin
        priority if (do_buy) state_nxt = ST_DIV;
        else if (do_sell) state_nxt = ST_SELL;
        else state_nxt = ST_MARK;
      end
      ST_DIV:   if (div_done) state_nxt = ST_MARK;
      ST_SELL:  if (phase_end) state_nxt = ST_MARK;
      ST_MARK:  if (phase_end) state_nxt = ST_DONE;
      ST_DONE:  if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, divider start and multiply operands
  always_comb begin
    in_tready   = (state_r == ST_IDLE);
    div_start   = (state_r == ST_TRADE) && do_buy;
    mac_req     = '0;
    mac_req.clr = (cnt_r == 3'd0);
    unique case (state_r)
      ST_FAST, ST_SLOW: begin
        mac_req.vld = (cnt_r < 3'd3);
        unique case (cnt_r)
          3'd0: begin
            mac_req.a  = (state_r == ST_FAST) ? fast_avg_r[31:0] : slow_avg_r[31:0];
            mac_req.b  = (state_r == ST_FAST) ? omw_fast : omw_slow;
            mac_req.sh = SH_NONE;
          end
          3'd1: begin
            mac_req.a  = (state_r == ST_FAST) ? 32'(fast_avg_r[AVG_W-1:32])
                                              : 32'(slow_avg_r[AVG_W-1:32]);
            mac_req.b  = (state_r == ST_FAST) ? omw_fast : omw_slow;
            mac_req.sh = SH_WORD;
          end
          3'd2: begin
            mac_req.a  = (state_r == ST_FAST) ? fast_wc : slow_wc;
            mac_req.b  = wp_r;
            mac_req.sh = SH_AVG;
          end
          default: mac_req.vld = 1'b0;
        endcase
      end
      ST_SELL, ST_MARK: begin
        mac_req.vld = (cnt_r < 3'd2);
        mac_req.b   = (state_r == ST_SELL) ? lp_r : wp_r;
        mac_req.a   = (cnt_r == 3'd0) ? hold_r[31:0] : hold_r[63:32];
        mac_req.sh  = (cnt_r == 3'd0) ? SH_NONE : SH_WORD;
      end
      default: mac_req.vld = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      primer_r    <= '0;
      primed_r    <= 1'b0;
      buy_pend_r  <= 1'b0;
      sell_pend_r <= 1'b0;
      buy_cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_nxt != state_r) ? 3'd0 : cnt_r + 1'b1;
      if (out_xfer) out_valid_r <= 1'b0;
      if (state_r == ST_DONE && slot_free) out_valid_r <= 1'b1;
      if (state_r == ST_TRADE) begin
        if (!primed_r) primer_r <= primer_inc;
        primed_r <= primed_now;
        if (primed_now) begin
          buy_pend_r  <= buy_now;
          sell_pend_r <= sell_now;
        end
      end
      if (state_r == ST_DIV && div_done && buy_cnt_r != '1) buy_cnt_r <= buy_cnt_r + 1'b1;
    end
  end

  // configuration registers and bar datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_w_r      <= FAST_WEIGHT_RST;
      slow_w_r      <= SLOW_WEIGHT_RST;
      prime_cnt_r   <= PRIME_COUNT_RST;
      fast_avg_r    <= '0;
      slow_avg_r    <= '0;
      prev_fast_r   <= '0;
      prev_slow_r   <= '0;
      cash_r        <= STARTING_BALANCE_RST;
      last_marked_r <= STARTING_BALANCE_RST;
      hold_r        <= '0;
    end else begin
      // bar capture
      if (in_xfer) begin
        wp_r        <= in_tdata[31:0];
        hp_r        <= in_tdata[63:32];
        lp_r        <= in_tdata[95:64];
        prev_fast_r <= fast_avg_r;
        prev_slow_r <= slow_avg_r;
      end
      // average updates
      if (state_r == ST_FAST && phase_end) fast_avg_r <= avg_shift[AVG_W-1:0];
      if (state_r == ST_SLOW && phase_end) slow_avg_r <= avg_shift[AVG_W-1:0];
      // trade decision
      if (state_r == ST_TRADE) begin
        new_buy_r  <= buy_now;
        new_sell_r <= sell_now;
        do_sell_r  <= do_sell;
      end
      // buy execution
      if (state_r == ST_DIV && div_done) begin
        hold_r <= hold_sum[HOLD_W] ? '1 : hold_sum[HOLD_W-1:0];
        cash_r <= '0;
      end
      // sell execution
      if (state_r == ST_SELL && phase_end && do_sell_r) begin
        cash_r <= cash_sat;
        hold_r <= '0;
      end
      // mark to market
      if (state_r == ST_MARK && phase_end) begin
        change_r      <= {1'b0, cash_sat} - {1'b0, last_marked_r};
        last_marked_r <= cash_sat;
      end
      // configuration transfer
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_FAST_WEIGHT: fast_w_r <= cfg_data[WEIGHT_W-1:0];
          REG_SLOW_WEIGHT: slow_w_r <= cfg_data[WEIGHT_W-1:0];
          REG_STARTING_BALANCE: begin
            cash_r        <= cfg_data[BAL_W-1:0];
            last_marked_r <= cfg_data[BAL_W-1:0];
            hold_r        <= '0;
          end
          REG_PRIME_COUNT: prime_cnt_r <= cfg_data[PRIME_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // result register load
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && slot_free) begin
      out_data_r <= {4'b0, buy_cnt_r, change_r, last_marked_r, slow_avg_r, fast_avg_r,
                     new_sell_r, new_buy_r, primed_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/core/ects_mac.sv @@
// ects_mac: shared 32x32 multiplier with registered product and shifting accumulator
// depends on ects_pkg
module ects_mac #(
  parameter int AVG_FRAC_BITS = ects_pkg::AVG_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ects_pkg::mac_req_t       req,
  output logic [ects_pkg::ACC_W-1:0] acc
);
  import ects_pkg::*;

  logic [63:0]      prod_r;
  logic             pend_r;
  logic             clr_r;
  shift_sel_t       sh_r;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] shifted;

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= req.vld;
    end
    prod_r <= req.a * req.b;
    clr_r  <= req.clr;
    sh_r   <= req.sh;
  end

  // alignment of the product
  always_comb begin
    unique case (sh_r)
      SH_NONE: shifted = ACC_W'(prod_r);
      SH_WORD: shifted = ACC_W'(prod_r) << 32;
      SH_AVG:  shifted = ACC_W'(prod_r) << AVG_FRAC_BITS;
      default: shifted = ACC_W'(prod_r);
    endcase
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (pend_r) begin
      acc_r <= clr_r ? shifted : acc_r + shifted;
    end
  end

  assign acc = acc_r;

endmodule

@@ rtl/core/ects_div.sv @@
// ects_div: bit-serial restoring divider, one quotient bit per cycle, 64-bit saturated result
// depends on ects_pkg
module ects_div #(
  parameter int NUM_W = 80
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  dividend,
  input  logic [31:0]       divisor,
  output logic              done,
  output logic [63:0]       quotient
);
  import ects_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [31:0]      rem_r;
  logic [31:0]      den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [32:0]      trial;
  logic             fits;
  logic [32:0]      diff;

  // one restoring step
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[31:0] : trial[31:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  // saturate to 64 bits
  generate
    if (NUM_W > 64) begin : g_sat
      assign quotient = (|quo_r[NUM_W-1:64]) ? '1 : quo_r[63:0];
    end else begin : g_fit
      assign quotient = 64'(quo_r);
    end
  endgenerate

  assign done = done_r;

endmodule
